/* rtl/core/logf_pkg.sv */
package logf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int KERNEL_SIZE = 5;
    localparam int HALF        = KERNEL_SIZE / 2;

    localparam int PIX_W  = 32;
    localparam int BYTE_W = 8;
    localparam int OUT_W  = 5;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + HALF + 1);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int TAP_W  = $clog2(KERNEL_SIZE);
    localparam int LS_W   = (KERNEL_SIZE - 1) * PIX_W;

    localparam int CFG_W     = 13;
    localparam int CFGW_W    = 11;
    localparam int CFGH_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int KW_W   = 6;
    localparam int PSUM_W = 13;
    localparam int SUM_W  = PSUM_W + $clog2(KERNEL_SIZE);

    localparam int CLAMP_MAX = 255;

    localparam logic signed [KW_W-1:0] LOG_KERNEL [KERNEL_SIZE][KERNEL_SIZE] = '{
        '{6'sd0, 6'sd0, 6'sd1,   6'sd0, 6'sd0},
        '{6'sd0, 6'sd1, 6'sd2,   6'sd1, 6'sd0},
        '{6'sd1, 6'sd2, -6'sd16, 6'sd2, 6'sd1},
        '{6'sd0, 6'sd1, 6'sd2,   6'sd1, 6'sd0},
        '{6'sd0, 6'sd0, 6'sd1,   6'sd0, 6'sd0}
    };

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t [KERNEL_SIZE-1:0] column_t;

    typedef struct packed {
        logic                   emit;
        logic                   fend;
        logic [KERNEL_SIZE-1:0] rmask;
        logic [KERNEL_SIZE-1:0] cmask;
    } tap_ctl_t;

    typedef struct packed {
        logic signed [PSUM_W-1:0] red;
        logic signed [PSUM_W-1:0] green;
        logic signed [PSUM_W-1:0] blue;
    } psum_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_t;

    // x / 9 for x in 0..255 as (x * 57) >> 9
    function automatic logic [OUT_W-1:0] div9(input logic [BYTE_W-1:0] x);
        logic [BYTE_W+5:0] prod;
        prod = (BYTE_W + 6)'(x) * (BYTE_W + 6)'(57);
        return prod[BYTE_W+5 -: OUT_W];
    endfunction

endpackage

/* rtl/core/logf_line_store.sv */
module logf_line_store (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [logf_pkg::COL_W-1:0] rd_addr,
    output logic [logf_pkg::LS_W-1:0]  rd_data,
    input  logic                       wr_en,
    input  logic [logf_pkg::COL_W-1:0] wr_addr,
    input  logic [logf_pkg::LS_W-1:0]  wr_data
);
    import logf_pkg::*;

    logic [LS_W-1:0] mem [MAX_WIDTH];
    logic [LS_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/logf_cell.sv */
module logf_cell (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic                       calc_en,
    input  logic [logf_pkg::TAP_W-1:0] tap_index,
    input  logf_pkg::tap_ctl_t         tap_ctl,
    input  logf_pkg::column_t          col_in,
    output logf_pkg::column_t          col_out,
    output logf_pkg::psum_t            psum
);
    import logf_pkg::*;

    column_t col_reg;
    psum_t   psum_reg;
    psum_t   psum_next;

    function automatic logic signed [PSUM_W-1:0] chan_sum(
        input column_t                col,
        input int                     ch,
        input logic [KERNEL_SIZE-1:0] rmask,
        input logic                   col_on,
        input logic [TAP_W-1:0]       tap
    );
        logic signed [PSUM_W-1:0] acc;
        logic signed [PSUM_W-1:0] wt;
        logic signed [PSUM_W-1:0] val;
        acc = '0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            wt  = PSUM_W'(LOG_KERNEL[i][tap]);
            val = PSUM_W'($signed({1'b0, col[i][ch*BYTE_W +: BYTE_W]}));
            if (rmask[i] && col_on) begin
                acc = acc + wt * val;
            end
        end
        return acc;
    endfunction

    always_comb begin
        psum_next.red   = chan_sum(col_reg, 0, tap_ctl.rmask, tap_ctl.cmask[tap_index],
                                   tap_index);
        psum_next.green = chan_sum(col_reg, 1, tap_ctl.rmask, tap_ctl.cmask[tap_index],
                                   tap_index);
        psum_next.blue  = chan_sum(col_reg, 2, tap_ctl.rmask, tap_ctl.cmask[tap_index],
                                   tap_index);
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
        if (calc_en) begin
            psum_reg <= psum_next;
        end
    end

    assign col_out = col_reg;
    assign psum    = psum_reg;

endmodule

/* rtl/core/logf_sum.sv */
module logf_sum (
    input  logic            aclk,
    input  logic            calc_en,
    input  logf_pkg::psum_t psum_in [logf_pkg::KERNEL_SIZE],
    output logf_pkg::rgb_t  clamped
);
    import logf_pkg::*;

    logic signed [SUM_W-1:0] sum_red;
    logic signed [SUM_W-1:0] sum_green;
    logic signed [SUM_W-1:0] sum_blue;
    rgb_t                    clamped_reg;
    rgb_t                    clamped_next;

    function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] s);
        if (s < 0) begin
            return '0;
        end
        if (s > CLAMP_MAX) begin
            return BYTE_W'(CLAMP_MAX);
        end
        return s[BYTE_W-1:0];
    endfunction

    always_comb begin
        sum_red   = '0;
        sum_green = '0;
        sum_blue  = '0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            sum_red   = sum_red   + SUM_W'(psum_in[k].red);
            sum_green = sum_green + SUM_W'(psum_in[k].green);
            sum_blue  = sum_blue  + SUM_W'(psum_in[k].blue);
        end
        clamped_next.red   = clamp_byte(sum_red);
        clamped_next.green = clamp_byte(sum_green);
        clamped_next.blue  = clamp_byte(sum_blue);
    end

    always_ff @(posedge aclk) begin
        if (calc_en) begin
            clamped_reg <= clamped_next;
        end
    end

    assign clamped = clamped_reg;

endmodule

/* rtl/core/log_5x5_rgb_filter.sv */
// Pipeline: request and line store read registers, window cells, partial sums, clamped
//   sum, output registers; results trail the input stream by two rows and two pixels.
// Throughput: one request per cycle, set by the single line store read port and the
//   five window cells that shift once per pixel; input stalls only while a result waits.
// Reset: synchronous, active low; clears position counters and pipeline valids,
//   sets both frame sizes to 1024. Line store and window are not cleared.
module log_5x5_rgb_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [logf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [logf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_flush,
    input  logic [logf_pkg::BYTE_W-1:0]    s_in_red,
    input  logic [logf_pkg::BYTE_W-1:0]    s_in_green,
    input  logic [logf_pkg::BYTE_W-1:0]    s_in_blue,
    input  logic [logf_pkg::BYTE_W-1:0]    s_in_alpha,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [logf_pkg::OUT_W-1:0]     m_out_red,
    output logic [logf_pkg::OUT_W-1:0]     m_out_green,
    output logic [logf_pkg::OUT_W-1:0]     m_out_blue,
    output logic [logf_pkg::BYTE_W-1:0]    m_out_alpha,
    output logic                           m_frame_end
);
    import logf_pkg::*;

    localparam int MIN_SIZE     = 3;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    function automatic logic [EW_W-1:0] clamp_width(input logic [CFGW_W-1:0] v);
        if (int'(v) < MIN_SIZE) begin
            return EW_W'(MIN_SIZE);
        end
        if (int'(v) > MAX_WIDTH) begin
            return EW_W'(MAX_WIDTH);
        end
        return EW_W'(v);
    endfunction

    function automatic logic [EH_W-1:0] clamp_height(input logic [CFGH_W-1:0] v);
        if (int'(v) < MIN_SIZE) begin
            return EH_W'(MIN_SIZE);
        end
        if (int'(v) > MAX_HEIGHT) begin
            return EH_W'(MAX_HEIGHT);
        end
        return EH_W'(v);
    endfunction

    logic [EW_W-1:0]   eff_w_reg, eff_w_next;
    logic [EH_W-1:0]   eff_h_reg, eff_h_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic     en;
    logic     accept;
    logic     in_active;
    logic     adv;
    logic     emit;
    logic     fend;
    pixel_t   pix;
    tap_ctl_t s0_ctl;

    tap_ctl_t         s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic             s1_adv_reg;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [BYTE_W-1:0] s3_alpha_reg, s4_alpha_reg;

    logic [LS_W-1:0] ls_rd_data;
    column_t         new_col;
    column_t         cell_in  [KERNEL_SIZE];
    column_t         cell_col [KERNEL_SIZE];
    psum_t           cell_psum [KERNEL_SIZE];
    rgb_t            clamped;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_red_reg, m_green_reg, m_blue_reg;
    logic [BYTE_W-1:0] m_alpha_reg;
    logic              m_fend_reg;

    assign en        = !(s4_ctl_reg.emit && m_valid_reg && !m_ready);
    assign s_ready   = en;
    assign accept    = s_valid && en;
    assign in_active = int'(in_row_reg) < int'(eff_h_reg);
    assign adv       = accept && (!s_flush || !in_active);
    assign emit      = adv && ((int'(in_row_reg) > HALF) ||
                               (int'(in_row_reg) == HALF && int'(in_col_reg) >= HALF));
    assign fend      = (int'(out_row_reg) == int'(eff_h_reg) - 1) &&
                       (int'(out_col_reg) == int'(eff_w_reg) - 1);
    assign pix       = in_active ? {s_in_alpha, s_in_blue, s_in_green, s_in_red} : '0;

    always_comb begin
        s0_ctl.emit = emit;
        s0_ctl.fend = fend;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            s0_ctl.rmask[i] = (int'(out_row_reg) + i >= HALF) &&
                              (int'(out_row_reg) + i < int'(eff_h_reg) + HALF);
            s0_ctl.cmask[i] = (int'(out_col_reg) + i >= HALF) &&
                              (int'(out_col_reg) + i < int'(eff_w_reg) + HALF);
        end
    end

    always_comb begin
        eff_w_next   = eff_w_reg;
        eff_h_next   = eff_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    eff_w_next = clamp_width(cfg_wdata[CFGW_W-1:0]);
                end
                REG_FRAME_HEIGHT: begin
                    eff_h_next = clamp_height(cfg_wdata[CFGH_W-1:0]);
                end
                default: begin
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end else if (adv) begin
            if (int'(in_col_reg) + 1 >= int'(eff_w_reg)) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit) begin
                if (int'(out_col_reg) + 1 >= int'(eff_w_reg)) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            if (emit && fend) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg   <= clamp_width(CFGW_W'(RESET_WIDTH));
            eff_h_reg   <= clamp_height(CFGH_W'(RESET_HEIGHT));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            eff_w_reg   <= eff_w_next;
            eff_h_reg   <= eff_h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s1_adv_reg <= 1'b0;
        end else if (en) begin
            s1_ctl_reg <= s0_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s1_adv_reg <= adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_pix_reg   <= pix;
            s1_addr_reg  <= in_col_reg;
            s3_alpha_reg <= cell_col[HALF][HALF][PIX_W-1 -: BYTE_W];
            s4_alpha_reg <= s3_alpha_reg;
        end
    end

    logf_line_store u_line_store (
        .aclk    (aclk),
        .en      (en),
        .rd_addr (in_col_reg),
        .rd_data (ls_rd_data),
        .wr_en   (en && s1_adv_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({s1_pix_reg, ls_rd_data[LS_W-1:PIX_W]})
    );

    assign new_col = {s1_pix_reg, ls_rd_data};

    genvar j;
    for (j = 0; j < KERNEL_SIZE; j++) begin : g_cell
        if (j == KERNEL_SIZE - 1) begin : g_head
            assign cell_in[j] = new_col;
        end else begin : g_link
            assign cell_in[j] = cell_col[j+1];
        end

        logf_cell u_cell (
            .aclk      (aclk),
            .shift_en  (en && s1_adv_reg),
            .calc_en   (en),
            .tap_index (TAP_W'(j)),
            .tap_ctl   (s2_ctl_reg),
            .col_in    (cell_in[j]),
            .col_out   (cell_col[j]),
            .psum      (cell_psum[j])
        );
    end

    logf_sum u_sum (
        .aclk    (aclk),
        .calc_en (en),
        .psum_in (cell_psum),
        .clamped (clamped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            if (s4_ctl_reg.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s4_ctl_reg.emit) begin
            m_red_reg   <= div9(clamped.red);
            m_green_reg <= div9(clamped.green);
            m_blue_reg  <= div9(clamped.blue);
            m_alpha_reg <= s4_alpha_reg;
            m_fend_reg  <= s4_ctl_reg.fend;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_red_reg;
    assign m_out_green = m_green_reg;
    assign m_out_blue  = m_blue_reg;
    assign m_out_alpha = m_alpha_reg;
    assign m_frame_end = m_fend_reg;

    a_in_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(in_col_reg) < int'(eff_w_reg))
        else $error("input column beyond frame width");

    a_out_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(out_row_reg) < int'(eff_h_reg)) && (int'(out_col_reg) < int'(eff_w_reg)))
        else $error("output position outside frame");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && fend && !cfg_wr_en) |=>
            (in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 &&
             out_row_reg == '0))
        else $error("frame end did not restart position counters");

endmodule
